// ----- design/u8sd_pkg.sv -----
// shared constants and decode helpers for the utf-8 stream decoder
package u8sd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int COUNT_W = 3;
    localparam int ACC_W   = 18;
    localparam int CONT_W  = 6;

    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK2     = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK3     = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK4     = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;

    localparam logic [COUNT_W-1:0] LEN_NONE = 3'd0;
    localparam logic [COUNT_W-1:0] LEN_1    = 3'd1;
    localparam logic [COUNT_W-1:0] LEN_2    = 3'd2;
    localparam logic [COUNT_W-1:0] LEN_3    = 3'd3;
    localparam logic [COUNT_W-1:0] LEN_4    = 3'd4;

    typedef logic [CP_W-1:0] t_code_point;

    function automatic logic [COUNT_W-1:0] length_of(input logic [BYTE_W-1:0] b);
        logic [COUNT_W-1:0] len;
        priority if (b >= LEAD4_MIN) len = LEN_4;
        else if (b >= LEAD3_MIN)     len = LEN_3;
        else if (b >= LEAD2_MIN)     len = LEN_2;
        else                         len = LEN_1;
        return len;
    endfunction

    function automatic t_code_point decode(input logic [BYTE_W-1:0] lead,
                                           input logic [ACC_W-1:0]  acc,
                                           input logic [COUNT_W-1:0] n);
        t_code_point cp;
        unique case (n)
            LEN_2:   cp = {10'd0, lead[4:0] & MASK2[4:0], acc[5:0]};
            LEN_3:   cp = {5'd0, lead[3:0] & MASK3[3:0], acc[11:0]};
            LEN_4:   cp = {lead[2:0] & MASK4[2:0], acc};
            default: cp = {13'd0, lead};
        endcase
        return cp;
    endfunction

endpackage

// ----- design/utf8_stream_decoder.sv -----
// utf-8 byte stream to code point decoder, one byte per beat
// a result is registered: it is valid in the cycle after the beat that completes its sequence
// throughput: one byte per cycle; a held result stalls input only while it is not taken
// bytes that complete no sequence are absorbed into the sequence state
// reset (synchronous, active low) closes any open sequence and empties the result register
module utf8_stream_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [u8sd_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_end_of_string,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [u8sd_pkg::CP_W-1:0]    o_code_point,
    output logic [u8sd_pkg::COUNT_W-1:0] o_byte_count
);
    import u8sd_pkg::*;

    logic [BYTE_W-1:0]  r_lead, n_lead;
    logic [COUNT_W-1:0] r_exp_len, n_exp_len;
    logic [COUNT_W-1:0] r_rx_cnt, n_rx_cnt;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic               r_out_valid, n_out_valid;
    t_code_point        r_code_point, n_code_point;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;

    logic               accept;
    logic [COUNT_W-1:0] lead_len;
    logic [ACC_W-1:0]   acc_shift;
    logic [COUNT_W-1:0] cnt_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign lead_len   = length_of(i_data_byte);
    assign acc_shift  = {r_acc[ACC_W-CONT_W-1:0], i_data_byte[CONT_W-1:0] & CONT_MASK[CONT_W-1:0]};
    assign cnt_inc    = r_rx_cnt + LEN_1;

    always_comb begin
        n_lead       = r_lead;
        n_exp_len    = r_exp_len;
        n_rx_cnt     = r_rx_cnt;
        n_acc        = r_acc;
        n_code_point = r_code_point;
        n_byte_count = r_byte_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        if (accept) begin
            if (r_exp_len == LEN_NONE) begin
                if (lead_len == LEN_1 || i_end_of_string) begin
                    // single byte or a lead that ends the string: plain byte value
                    n_code_point = {{(CP_W-BYTE_W){1'b0}}, i_data_byte};
                    n_byte_count = LEN_1;
                    n_out_valid  = 1'b1;
                end else begin
                    n_lead    = i_data_byte;
                    n_exp_len = lead_len;
                    n_rx_cnt  = LEN_1;
                    n_acc     = '0;
                end
            end else begin
                // any byte in an open sequence counts as continuation
                n_acc    = acc_shift;
                n_rx_cnt = cnt_inc;
                if (cnt_inc >= r_exp_len || i_end_of_string) begin
                    n_code_point = decode(r_lead, acc_shift, cnt_inc);
                    n_byte_count = cnt_inc;
                    n_out_valid  = 1'b1;
                    n_lead       = '0;
                    n_exp_len    = LEN_NONE;
                    n_rx_cnt     = LEN_NONE;
                    n_acc        = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead      <= '0;
            r_exp_len   <= LEN_NONE;
            r_rx_cnt    <= LEN_NONE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lead      <= n_lead;
            r_exp_len   <= n_exp_len;
            r_rx_cnt    <= n_rx_cnt;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code_point <= n_code_point;
        r_byte_count <= n_byte_count;
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_byte_count = r_byte_count;

endmodule

// ----- design/u8sd_checker.sv -----
// port-level assertions for the utf-8 stream decoder, bound to the decoder module
module u8sd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [u8sd_pkg::CP_W-1:0]    o_code_point,
    input logic [u8sd_pkg::COUNT_W-1:0] o_byte_count
);
    import u8sd_pkg::*;

    // a result beat always reports one to four bytes
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_count == LEN_1 || o_byte_count == LEN_2 ||
                         o_byte_count == LEN_3 || o_byte_count == LEN_4))
        else $error("byte count out of range");

    // code point width follows the byte count
    a_cp_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_byte_count == LEN_1 && o_code_point[CP_W-1:BYTE_W] == '0) ||
                         (o_byte_count == LEN_2 && o_code_point[CP_W-1:11] == '0) ||
                         (o_byte_count == LEN_3 && o_code_point[CP_W-1:16] == '0) ||
                         o_byte_count == LEN_4))
        else $error("code point wider than its byte count allows");

    // an empty or draining result register never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled with room in the result register");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_code_point)
                                        && $stable(o_byte_count))
        else $error("stalled result beat changed");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_code_point (o_code_point),
    .o_byte_count (o_byte_count)
);

// ----- tb/sv/u8sd_checker.sv -----
// utf-8 decoder checker: watches both channels, predicts code points and compares
`timescale 1ns / 1ps

module u8sd_tb_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [u8sd_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_end_of_string,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [u8sd_pkg::CP_W-1:0]    i_code_point,
    input  logic [u8sd_pkg::COUNT_W-1:0] i_byte_count,
    output int                           o_fail_count,
    output int                           o_pending
);
    import u8sd_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] byte_count;
    } t_symbol;

    t_symbol            expected_symbols[$];
    logic [BYTE_W-1:0]  seq_lead  = '0;
    logic [COUNT_W-1:0] seq_len   = LEN_NONE;
    logic [COUNT_W-1:0] seq_got   = '0;
    logic [ACC_W-1:0]   seq_bits  = '0;
    int                 mismatches = 0;

    function automatic t_code_point assemble(input logic [BYTE_W-1:0]  lead,
                                             input logic [ACC_W-1:0]   bits,
                                             input logic [COUNT_W-1:0] n);
        t_code_point cp;
        case (n)
            LEN_2:   cp = (t_code_point'(lead & MASK2) << 6)  | t_code_point'(bits[5:0]);
            LEN_3:   cp = (t_code_point'(lead & MASK3) << 12) | t_code_point'(bits[11:0]);
            LEN_4:   cp = (t_code_point'(lead & MASK4) << 18) | t_code_point'(bits);
            default: cp = t_code_point'(lead);
        endcase
        return cp;
    endfunction

    // one input beat through the sequence state; queues a code point when one closes
    task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [COUNT_W-1:0] len;
        t_symbol            sym;
        if (seq_len == LEN_NONE) begin
            if (b >= LEAD4_MIN)      len = LEN_4;
            else if (b >= LEAD3_MIN) len = LEN_3;
            else if (b >= LEAD2_MIN) len = LEN_2;
            else                     len = LEN_1;
            if (len == LEN_1 || last) begin
                sym.code_point = t_code_point'(b);
                sym.byte_count = LEN_1;
                expected_symbols.insert(expected_symbols.size(), sym);
            end else begin
                seq_lead = b;
                seq_len  = len;
                seq_got  = LEN_1;
                seq_bits = '0;
            end
        end else begin
            // any byte counts as a continuation, only its low six bits are kept
            seq_bits = {seq_bits[ACC_W-CONT_W-1:0], b[CONT_W-1:0]};
            seq_got  = seq_got + LEN_1;
            if (seq_got >= seq_len || last) begin
                sym.code_point = assemble(seq_lead, seq_bits, seq_got);
                sym.byte_count = seq_got;
                expected_symbols.insert(expected_symbols.size(), sym);
                seq_lead = '0;
                seq_len  = LEN_NONE;
                seq_got  = '0;
                seq_bits = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_symbol want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_symbols.size() == 0) begin
                    $error("unexpected result beat: code_point %h byte_count %0d",
                           i_code_point, i_byte_count);
                    mismatches++;
                end else begin
                    want = expected_symbols.pop_front();
                    if (i_code_point !== want.code_point) begin
                        $error("code_point mismatch: expected %h, actual %h",
                               want.code_point, i_code_point);
                        mismatches++;
                    end
                    if (i_byte_count !== want.byte_count) begin
                        $error("byte_count mismatch: expected %0d, actual %0d",
                               want.byte_count, i_byte_count);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_byte(i_data_byte, i_end_of_string);
        end
        o_pending    <= expected_symbols.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench top: drives utf-8 byte streams into the decoder and reports the verdict
`timescale 1ns / 1ps

module testbench;
    import u8sd_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                end_of_string = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CP_W-1:0]     code_point;
    logic [COUNT_W-1:0]  byte_count;
    int                  fail_count;
    int                  pending;

    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    bit                  stall_request = 1'b0;
    int                  stall_left    = 0;
    int                  bytes_sent    = 0;

    always #2 clk = ~clk;

    utf8_stream_decoder DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (data_byte),
        .i_end_of_string (end_of_string),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_code_point    (code_point),
        .o_byte_count    (byte_count)
    );

    u8sd_tb_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_data_byte     (data_byte),
        .i_end_of_string (end_of_string),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_code_point    (code_point),
        .i_byte_count    (byte_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left    = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_string <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] continuation_byte();
        // mostly well-formed 10xxxxxx, now and then any byte at all
        if ($urandom_range(9) == 0)
            return BYTE_W'($urandom_range(255));
        return {2'b10, CONT_W'($urandom)};
    endfunction

    task automatic send_random(input int count);
        int                 stop_at;
        int                 len;
        logic [BYTE_W-1:0]  lead;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 12) begin
                send_byte(BYTE_W'($urandom_range(255)), $urandom_range(7) == 0);
            end else begin
                len = $urandom_range(4, 1);
                case (len)
                    1:       lead = BYTE_W'($urandom_range(8'h7F, 8'h00));
                    2:       lead = BYTE_W'($urandom_range(LEAD3_MIN - 1, LEAD2_MIN));
                    3:       lead = BYTE_W'($urandom_range(LEAD4_MIN - 1, LEAD3_MIN));
                    default: lead = BYTE_W'($urandom_range(8'hFF, LEAD4_MIN));
                endcase
                send_byte(lead, (len == 1 || $urandom_range(15) == 0) ?
                                ($urandom_range(3) == 0) : 1'b0);
                for (int i = 1; i < len; i++)
                    send_byte(continuation_byte(),
                              (i == len - 1) ? ($urandom_range(3) == 0)
                                             : ($urandom_range(15) == 0));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 86;
        // plain ascii extremes and stray continuation bytes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h41, 1'b1);
        // smallest and largest of each sequence length
        send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b1);
        send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hF0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
        // lone lead closing a string
        send_byte(8'hC5, 1'b1);
        send_byte(8'hF4, 1'b1);
        // strings cut short inside a sequence
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b1);
        // lead-like byte taken as a continuation
        send_byte(8'hC3, 1'b0); send_byte(8'hF5, 1'b0);

        send_random(420);
        in_valid <= 1'b0;
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 32;
        send_random(430);
        in_valid <= 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b1;
        send_random(440);
        in_valid <= 1'b0;
        wait_drained();

        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
design/u8sd_pkg.sv
design/utf8_stream_decoder.sv
design/u8sd_checker.sv
tb/sv/u8sd_checker.sv
tb/sv/testbench.sv
